### hw/rtl/media_segment_timeline_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment timeline tracker
// Shared property forms so that every check is written the same way.
// ----------------------------------------------------------------------------
`ifndef MEDIA_SEGMENT_TIMELINE_TRACKER_ASSERT_SVH
`define MEDIA_SEGMENT_TIMELINE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSTT_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("timeline tracker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSTT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("timeline tracker: next-cycle check failed");

`endif

### hw/rtl/mstt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_pkg
// Types and constants of the segment timeline tracker.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int TICK_W   = 48;
    localparam int OP_W     = 4;
    localparam int STATUS_W = 3;
    localparam int SEGIDX_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // One millisecond in 100 ns ticks.
    localparam int MS_W = 14;
    localparam logic [MS_W-1:0] MS_TICKS = 14'd10000;

    localparam logic [TICK_W-1:0] PROGRESS_RESET    = 48'd100000000;
    localparam logic [TICK_W-1:0] DEFAULT_SEG_RESET = 48'd40000000;

    localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TICKS     = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 4'd0,
        OP_APPEND    = 4'd1,
        OP_START     = 4'd2,
        OP_ELAPSE    = 4'd3,
        OP_SEEK_FWD  = 4'd4,
        OP_SEEK_BACK = 4'd5,
        OP_PAUSE     = 4'd6,
        OP_STOP      = 4'd7,
        OP_PROGRESS  = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        MODE_IDLE     = 3'd0,
        MODE_PLAYING  = 3'd1,
        MODE_FINISHED = 3'd2,
        MODE_STOPPED  = 3'd3,
        MODE_ERROR    = 3'd4
    } mode_t;

endpackage

### hw/rtl/mstt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mstt_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/media_segment_timeline_tracker.sv
// Operations without a segment lookup pass through S_EXEC and S_RESP; a seek,
// and a start or an elapse that goes on playing, also run a binary search of
// up to ceil(log2(segments stored)) steps, each one RAM read and its compare,
// and a start or an elapse may then read and mark the segment. One item at a time.
// Reset clears the timeline state and the configuration to its defaults; the
// segment RAM needs no clearing pass since entries are read only once appended.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// media_segment_timeline_tracker
// Playback timeline over a RAM of segment end times with per-segment visited
// marks, binary search segment lookup and progress reporting.
// ----------------------------------------------------------------------------
`include "media_segment_timeline_tracker_assert.svh"

module media_segment_timeline_tracker #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mstt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mstt_pkg::TICK_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mstt_pkg::OP_W-1:0]          opcode,
    input  logic [mstt_pkg::TICK_W-1:0]        amount,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mstt_pkg::STATUS_W-1:0]      play_status,
    output logic                               pause_state,
    output logic [mstt_pkg::TICK_W-1:0]        position,
    output logic [mstt_pkg::SEGIDX_W-1:0]      segment_index,
    output logic                               fetch_request,
    output logic                               progress_report,
    output logic [mstt_pkg::TICK_W-1:0]        total_duration
);

    import mstt_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PW = TICK_W + MS_W;
    localparam int SW = PW + 1;
    localparam int RW = TICK_W + 1;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_EXEC      = 9'b000000010,
        S_ELAPSE    = 9'b000000100,
        S_FIND_REQ  = 9'b000001000,
        S_FIND_WAIT = 9'b000010000,
        S_FOUND     = 9'b000100000,
        S_MARK_REQ  = 9'b001000000,
        S_MARK_WAIT = 9'b010000000,
        S_RESP      = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [TICK_W-1:0]   amt_reg, amt_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [TICK_W-1:0]   pos_reg, pos_next;
    logic [TICK_W-1:0]   len_reg, len_next;
    logic [TICK_W-1:0]   last_reg, last_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                paused_reg, paused_next;
    mode_t               mode_reg, mode_next;
    logic                zero_mark_reg, zero_mark_next;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic                fetch_reg, fetch_next;
    logic                report_reg, report_next;
    logic [TICK_W-1:0]   interval_reg, interval_next;
    logic [TICK_W-1:0]   default_ticks_reg, default_ticks_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_out_reg, status_out_next;
    logic                paused_out_reg, paused_out_next;
    logic [TICK_W-1:0]   pos_out_reg, pos_out_next;
    logic [SEGIDX_W-1:0] seg_out_reg, seg_out_next;
    logic                fetch_out_reg, fetch_out_next;
    logic                report_out_reg, report_out_next;
    logic [TICK_W-1:0]   len_out_reg, len_out_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [RW-1:0]       ram_rdata;

    logic [TICK_W-1:0]   app_dur;
    logic [TICK_W:0]     app_sum;
    logic [TICK_W-1:0]   app_len;
    logic [TICK_W:0]     fwd_sum;
    logic [TICK_W-1:0]   fwd_pos;
    logic [TICK_W-1:0]   back_pos;
    logic [SW-1:0]       el_sum;
    logic                el_done;
    logic [TICK_W-1:0]   el_pos;
    logic [TICK_W-1:0]   prog_diff;
    logic [IW:0]         mid_sum;
    logic [IW-1:0]       mid;
    logic [IW-1:0]       hi_init;
    logic                cnt_empty;
    logic                out_free;

    mstt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Appended end times saturate at the largest tick count.
    assign app_dur = (amt_reg != '0) ? amt_reg : default_ticks_reg;
    assign app_sum = {1'b0, len_reg} + {1'b0, app_dur};
    assign app_len = app_sum[TICK_W] ? TICK_MAX : app_sum[TICK_W-1:0];

    assign fwd_sum = {1'b0, pos_reg} + {1'b0, amt_reg};
    always_comb
    begin
        if ((len_reg != '0) && (fwd_sum > {1'b0, len_reg}))
        begin
            fwd_pos = len_reg;
        end
        else if (fwd_sum[TICK_W])
        begin
            fwd_pos = TICK_MAX;
        end
        else
        begin
            fwd_pos = fwd_sum[TICK_W-1:0];
        end
    end

    assign back_pos = (pos_reg > amt_reg) ? (pos_reg - amt_reg) : '0;

    assign el_sum  = {{(SW - TICK_W){1'b0}}, pos_reg} + {1'b0, prod_reg};
    assign el_done = (len_reg != '0) && (el_sum >= {{(SW - TICK_W){1'b0}}, len_reg});
    assign el_pos  = (|el_sum[SW-1:TICK_W]) ? TICK_MAX : el_sum[TICK_W-1:0];

    assign prog_diff = pos_reg - last_reg;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[IW:1];
    assign cnt_empty = (cnt_reg == '0);
    assign hi_init   = cnt_empty ? '0 : IW'(cnt_reg - CW'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        amt_next           = amt_reg;
        prod_next          = prod_reg;
        pos_next           = pos_reg;
        len_next           = len_reg;
        last_next          = last_reg;
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        paused_next        = paused_reg;
        mode_next          = mode_reg;
        zero_mark_next     = zero_mark_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        fetch_next         = fetch_reg;
        report_next        = report_reg;
        interval_next      = interval_reg;
        default_ticks_next = default_ticks_reg;
        out_valid_next     = out_valid_reg;
        status_out_next    = status_out_reg;
        paused_out_next    = paused_out_reg;
        pos_out_next       = pos_out_reg;
        seg_out_next       = seg_out_reg;
        fetch_out_next     = fetch_out_reg;
        report_out_next    = report_out_reg;
        len_out_next       = len_out_reg;
        ram_we             = 1'b0;
        ram_waddr          = lo_reg;
        ram_wdata          = ram_rdata;
        ram_raddr          = lo_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PROGRESS_INTERVAL: interval_next      = cfg_data;
                CFG_DEFAULT_TICKS:     default_ticks_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(opcode);
                    amt_next    = amount;
                    fetch_next  = 1'b0;
                    report_next = 1'b0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        cnt_next       = '0;
                        len_next       = '0;
                        zero_mark_next = 1'b0;
                    end
                    OP_APPEND:
                    begin
                        if (cnt_reg < CW'(MAX_SEGMENTS))
                        begin
                            // A mark set while the table was empty belongs to entry 0.
                            ram_we    = 1'b1;
                            ram_waddr = cnt_reg[IW-1:0];
                            ram_wdata = {cnt_empty & zero_mark_reg, app_len};
                            len_next  = app_len;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    OP_START:
                    begin
                        pos_next    = amt_reg;
                        last_next   = '0;
                        paused_next = 1'b0;
                        if (cnt_empty || (len_reg == '0))
                        begin
                            mode_next = MODE_ERROR;
                        end
                        else
                        begin
                            if (amt_reg >= len_reg)
                            begin
                                pos_next = '0;
                            end
                            mode_next  = MODE_PLAYING;
                            lo_next    = '0;
                            hi_next    = hi_init;
                            state_next = S_FIND_REQ;
                        end
                    end
                    OP_ELAPSE:
                    begin
                        if ((mode_reg == MODE_PLAYING) && !paused_reg)
                        begin
                            prod_next  = PW'(amt_reg) * PW'(MS_TICKS);
                            state_next = S_ELAPSE;
                        end
                    end
                    OP_SEEK_FWD:
                    begin
                        pos_next   = fwd_pos;
                        lo_next    = '0;
                        hi_next    = hi_init;
                        state_next = S_FIND_REQ;
                    end
                    OP_SEEK_BACK:
                    begin
                        pos_next   = back_pos;
                        lo_next    = '0;
                        hi_next    = hi_init;
                        state_next = S_FIND_REQ;
                    end
                    OP_PAUSE:
                    begin
                        paused_next = !paused_reg;
                    end
                    OP_STOP:
                    begin
                        mode_next   = MODE_STOPPED;
                        paused_next = 1'b0;
                    end
                    OP_PROGRESS:
                    begin
                        if (prog_diff >= interval_reg)
                        begin
                            last_next   = pos_reg;
                            report_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            S_ELAPSE:
            begin
                if (el_done)
                begin
                    pos_next   = len_reg;
                    mode_next  = MODE_FINISHED;
                    state_next = S_RESP;
                end
                else
                begin
                    pos_next   = el_pos;
                    lo_next    = '0;
                    hi_next    = hi_init;
                    state_next = S_FIND_REQ;
                end
            end

            // Binary search for the first end time above the position; end
            // times never decrease, so the search settles on the last entry
            // when none is above it.
            S_FIND_REQ:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid;
                    state_next = S_FIND_WAIT;
                end
                else
                begin
                    state_next = S_FOUND;
                end
            end

            S_FIND_WAIT:
            begin
                if (pos_reg < ram_rdata[TICK_W-1:0])
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + IW'(1);
                end
                state_next = S_FIND_REQ;
            end

            S_FOUND:
            begin
                idx_next = lo_reg;
                case (op_reg)
                    OP_START:
                    begin
                        state_next = S_MARK_REQ;
                    end
                    OP_ELAPSE:
                    begin
                        if (lo_reg != idx_reg)
                        begin
                            state_next = S_MARK_REQ;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_MARK_REQ:
            begin
                if (cnt_empty)
                begin
                    // With an empty table the entry 0 mark lives in a flop.
                    fetch_next     = !zero_mark_reg;
                    zero_mark_next = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    ram_raddr  = lo_reg;
                    state_next = S_MARK_WAIT;
                end
            end

            S_MARK_WAIT:
            begin
                if (!ram_rdata[TICK_W])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = lo_reg;
                    ram_wdata = {1'b1, ram_rdata[TICK_W-1:0]};
                end
                fetch_next = (op_reg == OP_START) || !ram_rdata[TICK_W];
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = mode_reg;
                    paused_out_next = paused_reg;
                    pos_out_next    = pos_reg;
                    seg_out_next    = SEGIDX_W'(idx_reg);
                    fetch_out_next  = fetch_reg;
                    report_out_next = report_reg;
                    len_out_next    = len_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pos_reg           <= '0;
            len_reg           <= '0;
            last_reg          <= '0;
            idx_reg           <= '0;
            cnt_reg           <= '0;
            paused_reg        <= 1'b0;
            mode_reg          <= MODE_IDLE;
            zero_mark_reg     <= 1'b0;
            fetch_reg         <= 1'b0;
            report_reg        <= 1'b0;
            interval_reg      <= PROGRESS_RESET;
            default_ticks_reg <= DEFAULT_SEG_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pos_reg           <= pos_next;
            len_reg           <= len_next;
            last_reg          <= last_next;
            idx_reg           <= idx_next;
            cnt_reg           <= cnt_next;
            paused_reg        <= paused_next;
            mode_reg          <= mode_next;
            zero_mark_reg     <= zero_mark_next;
            fetch_reg         <= fetch_next;
            report_reg        <= report_next;
            interval_reg      <= interval_next;
            default_ticks_reg <= default_ticks_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        amt_reg        <= amt_next;
        prod_reg       <= prod_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        status_out_reg <= status_out_next;
        paused_out_reg <= paused_out_next;
        pos_out_reg    <= pos_out_next;
        seg_out_reg    <= seg_out_next;
        fetch_out_reg  <= fetch_out_next;
        report_out_reg <= report_out_next;
        len_out_reg    <= len_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign play_status     = status_out_reg;
    assign pause_state     = paused_out_reg;
    assign position        = pos_out_reg;
    assign segment_index   = seg_out_reg;
    assign fetch_request   = fetch_out_reg;
    assign progress_report = report_out_reg;
    assign total_duration  = len_out_reg;

    `MSTT_ASSERT_IMPLY(a_search_bounds, clk, rst_n, state_reg == S_FIND_WAIT, lo_reg < hi_reg)
    `MSTT_ASSERT_IMPLY(a_count_limit, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_SEGMENTS))
    `MSTT_ASSERT_IMPLY(a_ram_write_state, clk, rst_n, ram_we, (state_reg == S_EXEC) || (state_reg == S_MARK_WAIT))
    `MSTT_ASSERT_IMPLY(a_fetch_source, clk, rst_n, (state_reg == S_RESP) && fetch_reg, (op_reg == OP_START) || (op_reg == OP_ELAPSE))
    `MSTT_ASSERT_NEXT(a_result_issued, clk, rst_n, (state_reg == S_RESP) && out_free, out_valid_reg && (state_reg == S_IDLE))

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment timeline tracker. Operation transfers
// go in with random sender gaps and random result stalls. A predictor works
// out each status result and compares it field by field. The run covers an
// empty timeline, basic playback, register extremes, a full segment table and
// random playback sessions.
// ----------------------------------------------------------------------------
module tb_top;
    import mstt_pkg::*;

    localparam int          SEG_SLOTS    = 256;
    localparam int          IDLE_PCT     = 6;
    localparam int          STALL_PCT    = 6;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          ITEM_TARGET  = 530;
    localparam logic [63:0] TICKS_PER_MS = 64'd10000;
    localparam logic [63:0] TICK_CEIL    = {16'd0, TICK_MAX};

    // Opcodes with no defined operation.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                paused;
        logic [TICK_W-1:0]   pos;
        logic [SEGIDX_W-1:0] seg;
        logic                fetch;
        logic                report;
        logic [TICK_W-1:0]   total;
    } status_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode;
    logic [TICK_W-1:0]    amount;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  play_status;
    logic                 pause_state;
    logic [TICK_W-1:0]    position;
    logic [SEGIDX_W-1:0]  segment_index;
    logic                 fetch_request;
    logic                 progress_report;
    logic [TICK_W-1:0]    total_duration;

    media_segment_timeline_tracker DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .amount          (amount),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .play_status     (play_status),
        .pause_state     (pause_state),
        .position        (position),
        .segment_index   (segment_index),
        .fetch_request   (fetch_request),
        .progress_report (progress_report),
        .total_duration  (total_duration)
    );

    // Predicted timeline state, starting from its reset values.
    logic [TICK_W-1:0]   seg_end_ticks [SEG_SLOTS];
    bit                  seg_fetched [SEG_SLOTS];
    int unsigned         seg_entries  = 0;
    logic [TICK_W-1:0]   timeline_len = '0;
    logic [TICK_W-1:0]   play_pos     = '0;
    logic [TICK_W-1:0]   report_mark  = '0;
    logic [SEGIDX_W-1:0] cur_seg      = '0;
    bit                  paused       = 1'b0;
    mode_t               mode         = MODE_IDLE;
    logic [TICK_W-1:0]   report_every = PROGRESS_RESET;
    logic [TICK_W-1:0]   default_dur  = DEFAULT_SEG_RESET;

    status_word_t status_expect_q [$];
    int           mismatches   = 0;
    int           items_sent   = 0;
    int           results_seen = 0;
    bit           steady       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [SEGIDX_W-1:0] locate_segment(logic [TICK_W-1:0] p);
        for (int i = 0; i < seg_entries; i++)
        begin
            if (p < seg_end_ticks[i])
                return SEGIDX_W'(i);
        end
        return (seg_entries == 0) ? '0 : SEGIDX_W'(seg_entries - 1);
    endfunction

    function automatic bit claim_segment(logic [SEGIDX_W-1:0] idx);
        if (seg_fetched[idx])
            return 1'b0;
        seg_fetched[idx] = 1'b1;
        return 1'b1;
    endfunction

    // Applies one operation to the predicted state and returns its status.
    function automatic status_word_t step_timeline(logic [OP_W-1:0] op,
                                                   logic [TICK_W-1:0] amt);
        logic [63:0]         sum;
        logic [SEGIDX_W-1:0] seg;
        status_word_t        r;
        bit                  fetch;
        bit                  report;
        fetch  = 1'b0;
        report = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                seg_entries  = 0;
                timeline_len = '0;
                foreach (seg_fetched[i])
                    seg_fetched[i] = 1'b0;
            end
            OP_APPEND:
            begin
                if (seg_entries < SEG_SLOTS)
                begin
                    sum = {16'd0, timeline_len} + {16'd0, (amt != '0) ? amt : default_dur};
                    if (sum > TICK_CEIL)
                        sum = TICK_CEIL;
                    timeline_len = sum[TICK_W-1:0];
                    seg_end_ticks[seg_entries] = timeline_len;
                    seg_entries++;
                end
            end
            OP_START:
            begin
                play_pos    = amt;
                report_mark = '0;
                paused      = 1'b0;
                if (seg_entries == 0 || timeline_len == '0)
                    mode = MODE_ERROR;
                else
                begin
                    if (play_pos >= timeline_len)
                        play_pos = '0;
                    cur_seg = locate_segment(play_pos);
                    void'(claim_segment(cur_seg));
                    fetch = 1'b1;
                    mode  = MODE_PLAYING;
                end
            end
            OP_ELAPSE:
            begin
                if (mode == MODE_PLAYING && !paused)
                begin
                    sum = {16'd0, play_pos} + {16'd0, amt} * TICKS_PER_MS;
                    if (timeline_len != '0 && sum >= {16'd0, timeline_len})
                    begin
                        play_pos = timeline_len;
                        mode     = MODE_FINISHED;
                    end
                    else
                    begin
                        if (sum > TICK_CEIL)
                            sum = TICK_CEIL;
                        play_pos = sum[TICK_W-1:0];
                        seg = locate_segment(play_pos);
                        if (seg != cur_seg)
                        begin
                            cur_seg = seg;
                            fetch   = claim_segment(seg);
                        end
                    end
                end
            end
            OP_SEEK_FWD:
            begin
                sum = {16'd0, play_pos} + {16'd0, amt};
                if (timeline_len != '0 && sum > {16'd0, timeline_len})
                    sum = {16'd0, timeline_len};
                if (sum > TICK_CEIL)
                    sum = TICK_CEIL;
                play_pos = sum[TICK_W-1:0];
                cur_seg  = locate_segment(play_pos);
            end
            OP_SEEK_BACK:
            begin
                play_pos = (play_pos > amt) ? play_pos - amt : '0;
                cur_seg  = locate_segment(play_pos);
            end
            OP_PAUSE:
                paused = !paused;
            OP_STOP:
            begin
                mode   = MODE_STOPPED;
                paused = 1'b0;
            end
            OP_PROGRESS:
            begin
                // The distance wraps at 48 bits when a seek went behind the mark.
                if (TICK_W'(play_pos - report_mark) >= report_every)
                begin
                    report_mark = play_pos;
                    report      = 1'b1;
                end
            end
            default:
                ;
        endcase
        r.status = mode;
        r.paused = paused;
        r.pos    = play_pos;
        r.seg    = cur_seg;
        r.fetch  = fetch;
        r.report = report;
        r.total  = timeline_len;
        return r;
    endfunction

    function automatic logic [TICK_W-1:0] random_ticks();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TICK_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] rand_upto(logic [TICK_W-1:0] lim);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (lim == TICK_MAX)
            return r[TICK_W-1:0];
        return TICK_W'(r % ({16'd0, lim} + 64'd1));
    endfunction

    function automatic logic [TICK_W-1:0] segment_ticks();
        int pick;
        pick = $urandom_range(0, 39);
        if (pick < 4)
            return '0;
        if (pick == 4)
            return random_ticks();
        return TICK_W'($urandom_range(10000, 3000000));
    endfunction

    task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch in %0s at result %0d: got 0x%0h, expected 0x%0h",
                 field, results_seen, got, want);
    endtask

    // Sends one operation and records its predicted status once the transfer
    // has happened. Valid stays high into the next call unless a gap is taken.
    task automatic send_op(logic [OP_W-1:0] op, logic [TICK_W-1:0] amt);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        amount   <= amt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        status_expect_q.push_back(step_timeline(op, amt));
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_expect_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_PROGRESS_INTERVAL)
            report_every = val;
        else
            default_dur = val;
    endtask

    // One random playback operation; elapse, start and most seek amounts are scaled to the current timeline.
    task automatic playback_op();
        int                pick;
        logic [TICK_W-1:0] span;
        pick = $urandom_range(0, 99);
        span = (timeline_len == '0) ? 48'd1000000 : timeline_len;
        if (pick < 36)
            send_op(OP_ELAPSE, rand_upto(span / 40000 + 1));
        else if (pick < 50)
            send_op(OP_SEEK_FWD, ($urandom_range(0, 15) == 0) ? random_ticks()
                                                               : rand_upto(span / 3));
        else if (pick < 64)
            send_op(OP_SEEK_BACK, ($urandom_range(0, 15) == 0) ? random_ticks()
                                                                : rand_upto(span / 3));
        else if (pick < 80)
            send_op(OP_PROGRESS, random_ticks());
        else if (pick < 85)
            send_op(OP_PAUSE, random_ticks());
        else if (pick < 88)
            send_op(OP_STOP, random_ticks());
        else if (pick < 95)
            send_op(OP_START, rand_upto(span + span / 8));
        else
            send_op(OP_APPEND, segment_ticks());
    endtask

    // A fresh table and a start, then playback. Now and then the clear or the
    // start is left out, and some operations are pure noise.
    task automatic run_session();
        int n_ops;
        n_ops = $urandom_range(8, 24);
        if ($urandom_range(0, 9) != 0)
            send_op(OP_CLEAR, random_ticks());
        repeat ($urandom_range(1, 12)) send_op(OP_APPEND, segment_ticks());
        if ($urandom_range(0, 9) != 0)
            send_op(OP_START, rand_upto(timeline_len));
        repeat (n_ops)
        begin
            if ($urandom_range(0, 19) == 0)
                send_op(OP_W'($urandom_range(0, 15)), random_ticks());
            else
                playback_op();
        end
    endtask

    task automatic test_idle_timeline();
        send_op(OP_START, 48'd1234);
        send_op(OP_ELAPSE, 48'd5);
        send_op(OP_SEEK_FWD, TICK_MAX);
        send_op(OP_SEEK_BACK, 48'd1);
        send_op(OP_SEEK_BACK, TICK_MAX);
        send_op(OP_PAUSE, '0);
        send_op(OP_PROGRESS, '0);
        send_op(OP_PAUSE, '0);
        send_op(OP_STOP, '0);
        send_op(OP_UNUSED_LO, TICK_MAX);
        send_op(OP_UNUSED_HI, 48'h5555_5555_5555);
    endtask

    task automatic test_basic_playback();
        send_op(OP_APPEND, '0);
        send_op(OP_APPEND, 48'd15000000);
        send_op(OP_APPEND, 48'd1);
        // Lands exactly on the end of the first segment.
        send_op(OP_START, 48'd40000000);
        send_op(OP_ELAPSE, 48'd1500);
        send_op(OP_PROGRESS, '0);
        send_op(OP_SEEK_BACK, TICK_MAX);
        send_op(OP_ELAPSE, 48'd4000);
        send_op(OP_PAUSE, '0);
        send_op(OP_ELAPSE, 48'd100);
        send_op(OP_PAUSE, '0);
        send_op(OP_SEEK_FWD, TICK_MAX);
        send_op(OP_PROGRESS, '0);
        send_op(OP_ELAPSE, 48'd0);
        send_op(OP_ELAPSE, 48'd1);
        send_op(OP_START, TICK_MAX);
        send_op(OP_STOP, 48'd7);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_PROGRESS_INTERVAL, '0);
        write_reg(CFG_DEFAULT_TICKS, '0);
        send_op(OP_CLEAR, TICK_MAX);
        send_op(OP_APPEND, '0);
        // One segment but no length yet.
        send_op(OP_START, 48'd3);
        send_op(OP_PROGRESS, '0);
        write_reg(CFG_DEFAULT_TICKS, TICK_MAX);
        send_op(OP_APPEND, '0);
        send_op(OP_APPEND, 48'd5);
        send_op(OP_START, 48'd5);
        // Playing over an emptied table: the position runs up to the ceiling.
        send_op(OP_CLEAR, '0);
        send_op(OP_ELAPSE, TICK_MAX);
        write_reg(CFG_PROGRESS_INTERVAL, TICK_MAX);
        send_op(OP_PROGRESS, '0);
        send_op(OP_PROGRESS, '0);
        write_reg(CFG_PROGRESS_INTERVAL, PROGRESS_RESET);
        write_reg(CFG_DEFAULT_TICKS, DEFAULT_SEG_RESET);
    endtask

    task automatic test_full_table();
        send_op(OP_CLEAR, random_ticks());
        repeat (SEG_SLOTS + 4) send_op(OP_APPEND, segment_ticks());
        send_op(OP_START, rand_upto(timeline_len));
        repeat (16) playback_op();
    endtask

    task automatic test_random_sessions();
        int session;
        session = 0;
        steady  = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            if (session == 3)
                steady = 1'b0;
            // Hold the sender until every result is back.
            if (session == 5)
                drain_results();
            if (session % 3 == 2)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_PROGRESS_INTERVAL, '0);
                    1:       write_reg(CFG_PROGRESS_INTERVAL, TICK_MAX);
                    default: write_reg(CFG_PROGRESS_INTERVAL, rand_upto(48'd8000000));
                endcase
                write_reg(CFG_DEFAULT_TICKS,
                          ($urandom_range(0, 1) == 0) ? '0 : rand_upto(48'd5000000));
            end
            run_session();
            session++;
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < STALL_PCT);

    always @(posedge clk)
    begin : check_results
        status_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (status_expect_q.size() == 0)
                flag_mismatch("result with nothing expected", '0, '0);
            else
            begin
                want = status_expect_q.pop_front();
                if (play_status !== want.status)
                    flag_mismatch("play_status", play_status, want.status);
                if (pause_state !== want.paused)
                    flag_mismatch("pause_state", pause_state, want.paused);
                if (position !== want.pos)
                    flag_mismatch("position", position, want.pos);
                if (segment_index !== want.seg)
                    flag_mismatch("segment_index", segment_index, want.seg);
                if (fetch_request !== want.fetch)
                    flag_mismatch("fetch_request", fetch_request, want.fetch);
                if (progress_report !== want.report)
                    flag_mismatch("progress_report", progress_report, want.report);
                if (total_duration !== want.total)
                    flag_mismatch("total_duration", total_duration, want.total);
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_PROGRESS_INTERVAL;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        opcode    <= OP_CLEAR;
        amount    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_timeline();
        test_basic_playback();
        test_register_extremes();
        test_full_table();
        test_random_sessions();
        drain_results();
        repeat (40) @(posedge clk);
        if (status_expect_q.size() != 0)
            flag_mismatch("results never delivered", status_expect_q.size(), '0);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
